### rtl/tls_pkg.sv
// Shared types and constants for the traffic light sequencer.
// No dependencies.
package tls_pkg;

  localparam logic [1:0] PH_STOP = 2'd0;
  localparam logic [1:0] PH_GO   = 2'd1;
  localparam logic [1:0] PH_WARN = 2'd2;
  localparam logic [1:0] PH_OFF  = 2'd3;

  localparam logic CFG_BASE_PERIOD = 1'b0;
  localparam logic CFG_HOLD_PERIOD = 1'b1;

  localparam logic [31:0] BASE_PERIOD_RST = 32'h04C4_B400;
  localparam logic [31:0] HOLD_PERIOD_RST = 32'h01E8_4800;

  typedef struct packed {
    logic ped;
    logic power;
  } tick_t;

endpackage

### rtl/tls_core.sv
// Light phase, base countdown and hold countdown of the traffic light sequencer.
// Depends on tls_pkg.
module tls_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  tls_pkg::tick_t      tick,
  input  logic [31:0]         base_period,
  input  logic [31:0]         hold_period,
  output logic [1:0]          phase_nxt
);

  function automatic logic [COUNT_WIDTH-1:0] eff_period(input logic [31:0] p);
    logic [63:0]            w;
    logic [COUNT_WIDTH-1:0] v;
    w = {32'd0, p};
    v = w[COUNT_WIDTH-1:0];
    return (v == '0) ? COUNT_WIDTH'(1) : v;
  endfunction

  logic [1:0]             phase_r;
  logic [COUNT_WIDTH-1:0] base_count_r, base_count_nxt;
  logic [COUNT_WIDTH-1:0] hold_count_r, hold_count_nxt;
  logic                   running_r, running_nxt;
  logic [COUNT_WIDTH-1:0] eff_base, eff_hold, hold_inc;
  logic                   base_exp, press;

  assign eff_base = eff_period(base_period);
  assign eff_hold = eff_period(hold_period);
  assign base_exp = running_r && (base_count_r <= COUNT_WIDTH'(1));
  assign press    = tick.power || (tick.ped && (phase_r == tls_pkg::PH_GO));
  assign hold_inc = (hold_count_r != '1) ? hold_count_r + COUNT_WIDTH'(1) : hold_count_r;

  always_comb begin
    phase_nxt      = phase_r;
    running_nxt    = running_r;
    hold_count_nxt = hold_count_r;
    base_count_nxt = base_count_r;
    if (running_r) begin
      base_count_nxt = base_exp ? eff_base : base_count_r - COUNT_WIDTH'(1);
    end
    if (base_exp) begin
      hold_count_nxt = '0;
      if (phase_r != tls_pkg::PH_OFF) begin
        phase_nxt = (phase_r == tls_pkg::PH_STOP) ? tls_pkg::PH_GO : tls_pkg::PH_STOP;
      end
    end else if (press) begin
      if (hold_inc >= eff_hold) begin
        hold_count_nxt = '0;
        base_count_nxt = eff_base;
        if (tick.power) begin
          if (phase_r == tls_pkg::PH_OFF) begin
            phase_nxt   = tls_pkg::PH_STOP;
            running_nxt = 1'b1;
          end else begin
            phase_nxt   = tls_pkg::PH_OFF;
            running_nxt = 1'b0;
          end
        end else begin
          phase_nxt   = tls_pkg::PH_WARN;
          running_nxt = 1'b1;
        end
      end else begin
        hold_count_nxt = hold_inc;
      end
    end else begin
      hold_count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= tls_pkg::PH_STOP;
      base_count_r <= eff_period(tls_pkg::BASE_PERIOD_RST);
      running_r    <= 1'b1;
      hold_count_r <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      base_count_r <= base_count_nxt;
      running_r    <= running_nxt;
      hold_count_r <= hold_count_nxt;
    end
  end

endmodule

### rtl/traffic_light_sequencer.sv
// Traffic light sequencer: one timer tick per request, one lamp/phase result per tick.
// Accepts a request in every clock; its result is in the output register on the next
// cycle. in_tready drops only while a result waits and out_tready is low, since the
// single output register is the only buffering. Depends on tls_pkg and tls_core.
module traffic_light_sequencer #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [0] power_button, [1] ped_button, [7:2] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [0] red, [1] yellow, [2] green, [4:3] light_phase
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [31:0]    base_period_r, hold_period_r;
  logic           out_valid_r;
  logic [7:0]     out_data_r;
  logic           accept;
  logic [1:0]     phase_nxt;
  tls_pkg::tick_t tick;

  assign tick.power = in_tdata[0];
  assign tick.ped   = in_tdata[1];
  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  tls_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (accept),
    .tick       (tick),
    .base_period(base_period_r),
    .hold_period(hold_period_r),
    .phase_nxt  (phase_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_period_r <= tls_pkg::BASE_PERIOD_RST;
      hold_period_r <= tls_pkg::HOLD_PERIOD_RST;
    end else if (cfg_we) begin
      if (cfg_index == tls_pkg::CFG_BASE_PERIOD) begin
        base_period_r <= cfg_wdata;
      end else begin
        hold_period_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {3'b000, phase_nxt,
                     phase_nxt == tls_pkg::PH_GO,
                     phase_nxt == tls_pkg::PH_WARN,
                     phase_nxt == tls_pkg::PH_STOP};
    end
  end

endmodule

### rtl/tls_checker.sv
// Port-level checks for the traffic light sequencer, bound to the top level.
// Depends on tls_pkg and traffic_light_sequencer.
module tls_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_lamps: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      out_tdata[0] == (out_tdata[4:3] == tls_pkg::PH_STOP) &&
      out_tdata[1] == (out_tdata[4:3] == tls_pkg::PH_WARN) &&
      out_tdata[2] == (out_tdata[4:3] == tls_pkg::PH_GO))
    else $error("lamps disagree with phase");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("request refused with room in output");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted request gave no result");

endmodule

bind traffic_light_sequencer tls_checker u_tls_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

### dv/tb.sv
// Self-checking bench for traffic_light_sequencer: timer ticks on the request stream,
// lamp/phase results checked in order against a behavioral model of the light sequence.
// Depends on tls_pkg and the traffic_light_sequencer RTL.
module tb;
  import tls_pkg::*;

  localparam int LIMIT      = 400000;
  localparam int RAND_TICKS = 1300;
  localparam int N_SETTINGS = 9;

  typedef struct packed {
    logic [1:0] ph;
    logic       grn;
    logic       yel;
    logic       red;
  } lamps_t;

  typedef struct {
    bit          is_cfg;
    logic        idx;
    logic [31:0] val;
    logic        pw;
    logic        pd;
    bit          typed;
    logic [1:0]  ph;
  } stim_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = 1'b0;
  logic [31:0] cfg_wdata  = 32'd0;

  // model of the sequencer
  logic [31:0] base_per, hold_per, base_cnt, hold_cnt;
  logic [1:0]  light_ph;
  logic        base_run;

  lamps_t lamp_expect[$];
  int     ticks_sent, results_seen, mism_cnt, settings_run, cycles;
  int     ph_seen[4];
  int     tx_idle_pct, rx_idle_pct;
  logic   stall_kick = 1'b0;
  logic   stall_seen = 1'b0;
  int     stall_left = 0;

  traffic_light_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] eff_period(input logic [31:0] p);
    return (p == 32'd0) ? 32'd1 : p;
  endfunction

  function automatic lamps_t decode_lamps(input logic [1:0] ph);
    lamps_t l;
    l.ph  = ph;
    l.red = (ph == PH_STOP);
    l.yel = (ph == PH_WARN);
    l.grn = (ph == PH_GO);
    return l;
  endfunction

  function void reset_lights();
    base_per = BASE_PERIOD_RST;
    hold_per = HOLD_PERIOD_RST;
    light_ph = PH_STOP;
    base_cnt = eff_period(BASE_PERIOD_RST);
    base_run = 1'b1;
    hold_cnt = 32'd0;
  endfunction

  function void advance_lights(input logic pw, input logic pd);
    logic expired;
    expired = 1'b0;
    if (base_run) begin
      if (base_cnt <= 32'd1) begin
        expired  = 1'b1;
        base_cnt = eff_period(base_per);
      end else begin
        base_cnt = base_cnt - 32'd1;
      end
    end
    if (expired) begin
      if (light_ph != PH_OFF) light_ph = (light_ph == PH_STOP) ? PH_GO : PH_STOP;
      hold_cnt = 32'd0;
    end else if (pw || (pd && light_ph == PH_GO)) begin
      if (hold_cnt != 32'hFFFF_FFFF) hold_cnt = hold_cnt + 32'd1;
      if (hold_cnt >= eff_period(hold_per)) begin
        hold_cnt = 32'd0;
        base_cnt = eff_period(base_per);
        if (pw) begin
          if (light_ph == PH_OFF) begin
            light_ph = PH_STOP;
            base_run = 1'b1;
          end else begin
            light_ph = PH_OFF;
            base_run = 1'b0;
          end
        end else begin
          light_ph = PH_WARN;
          base_run = 1'b1;
        end
      end
    end else begin
      hold_cnt = 32'd0;
    end
    ph_seen[light_ph]++;
  endfunction

  function automatic stim_row_t tk(input logic pw, input logic pd);
    return '{1'b0, CFG_BASE_PERIOD, 32'd0, pw, pd, 1'b0, PH_STOP};
  endfunction

  function automatic stim_row_t tkx(input logic pw, input logic pd, input logic [1:0] ph);
    return '{1'b0, CFG_BASE_PERIOD, 32'd0, pw, pd, 1'b1, ph};
  endfunction

  function automatic stim_row_t cf(input logic idx, input logic [31:0] val);
    return '{1'b1, idx, val, 1'b0, 1'b0, 1'b0, PH_STOP};
  endfunction

  task automatic put_tick(input logic pw, input logic pd, input bit typed,
                          input logic [1:0] typed_ph);
    tick_t req;
    req.power = pw;
    req.ped   = pd;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, req};
    do @(posedge clk); while (!in_tready);
    advance_lights(pw, pd);
    lamp_expect.push_back(typed ? decode_lamps(typed_ph) : decode_lamps(light_ph));
    ticks_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (lamp_expect.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_BASE_PERIOD) base_per = val;
    else hold_per = val;
  endtask

  // one press pattern: long power press, pedestrian press in go (maybe handed over
  // to power), quiet stretch, or random button noise
  task automatic random_burst();
    int          kind, len, hl, k;
    logic [31:0] hp;
    hp   = eff_period(hold_per);
    hl   = (hp > 32'd24) ? int'($urandom_range(1, 24)) : int'(hp);
    kind = $urandom_range(9);
    if (kind <= 3) begin
      len = hl + int'($urandom_range(2)) - 1;
      if (len < 1) len = 1;
      for (k = 0; k < len; k++) put_tick(1'b1, 1'($urandom_range(1)), 1'b0, PH_STOP);
    end else if (kind <= 6) begin
      for (k = 0; k < 30 && light_ph != PH_GO; k++) put_tick(1'b0, 1'b0, 1'b0, PH_STOP);
      len = hl + int'($urandom_range(2)) - 1;
      if (len < 1) len = 1;
      for (k = 0; k < len; k++) put_tick(1'b0, 1'b1, 1'b0, PH_STOP);
      if ($urandom_range(1) == 0) begin
        len = $urandom_range(1, hl);
        for (k = 0; k < len; k++) put_tick(1'b1, 1'($urandom_range(1)), 1'b0, PH_STOP);
      end
    end else if (kind == 7) begin
      len = $urandom_range(1, 12);
      for (k = 0; k < len; k++) put_tick(1'b0, 1'b0, 1'b0, PH_STOP);
    end else begin
      len = $urandom_range(1, 6);
      for (k = 0; k < len; k++)
        put_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, PH_STOP);
    end
  endtask

  // receiver: random backpressure, plus a long hold-off on each toggle of stall_kick
  always @(posedge clk) begin
    if (stall_kick != stall_seen) begin
      stall_seen <= stall_kick;
      stall_left <= 60;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    lamps_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[4:0];
      results_seen++;
      if (lamp_expect.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= 10)
          $display("unexpected result %0d: red=%b yel=%b grn=%b ph=%0d",
                   results_seen, got.red, got.yel, got.grn, got.ph);
      end else begin
        want = lamp_expect.pop_front();
        if (got.red !== want.red || got.yel !== want.yel ||
            got.grn !== want.grn || got.ph !== want.ph) begin
          mism_cnt++;
          if (mism_cnt <= 10)
            $display("result %0d: exp red=%b yel=%b grn=%b ph=%0d, got red=%b yel=%b grn=%b ph=%0d",
                     results_seen, want.red, want.yel, want.grn, want.ph,
                     got.red, got.yel, got.grn, got.ph);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    stim_row_t   dir_rows[$];
    logic [31:0] bp, hp;
    int          p, start, fails;
    bit          paused, stalled;
    paused  = 1'b0;
    stalled = 1'b0;
    reset_lights();
    tx_idle_pct = 6;
    rx_idle_pct = 54;

    dir_rows = '{
      // reset periods: nothing can expire or complete
      tkx(0, 0, PH_STOP), tkx(1, 1, PH_STOP), tkx(0, 1, PH_STOP), tkx(1, 0, PH_STOP),
      // zero periods act as one
      cf(CFG_BASE_PERIOD, 32'd0), cf(CFG_HOLD_PERIOD, 32'd0),
      tkx(1, 0, PH_OFF), tkx(0, 0, PH_OFF), tkx(1, 1, PH_STOP), tkx(0, 0, PH_GO),
      tkx(0, 1, PH_STOP), tkx(1, 0, PH_GO), tkx(0, 0, PH_STOP),
      // pedestrian to warn, power off/on, pedestrian handed over to power
      cf(CFG_BASE_PERIOD, 32'd3), cf(CFG_HOLD_PERIOD, 32'd2),
      tk(0, 0), tk(0, 1), tk(0, 1), tk(1, 0), tk(1, 0), tk(1, 0), tk(1, 0),
      tk(0, 0), tk(0, 0), tk(0, 0), tk(0, 1), tk(1, 0),
      cf(CFG_BASE_PERIOD, 32'hFFFF_FFFF), cf(CFG_HOLD_PERIOD, 32'hFFFF_FFFF),
      tk(1, 1), tk(0, 0)
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_reg(dir_rows[i].idx, dir_rows[i].val);
      else put_tick(dir_rows[i].pw, dir_rows[i].pd, dir_rows[i].typed, dir_rows[i].ph);
    end

    for (p = 0; p < N_SETTINGS; p++) begin
      case (p)
        0: begin bp = 32'd5;          hp = 32'd3;          end
        1: begin bp = 32'd1;          hp = 32'd1;          end
        2: begin bp = 32'd0;          hp = 32'd0;          end
        3: begin bp = 32'hFFFF_FFFF;  hp = 32'd2;          end
        4: begin bp = 32'd12;         hp = 32'hFFFF_FFFF;  end
        default: begin
          bp = $urandom_range(2, 16);
          hp = $urandom_range(1, 10);
        end
      endcase
      case (p / 3)
        0: begin tx_idle_pct = 6;  rx_idle_pct = 54; end
        1: begin tx_idle_pct = 54; rx_idle_pct = 6;  end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      write_reg(CFG_BASE_PERIOD, bp);
      write_reg(CFG_HOLD_PERIOD, hp);
      settings_run++;
      start = ticks_sent;
      while (ticks_sent - start < RAND_TICKS / N_SETTINGS) begin
        if (p == 6 && !paused && ticks_sent - start >= 60) begin
          drain();
          paused = 1'b1;
        end
        if (p == 7 && !stalled && ticks_sent - start >= 60) begin
          stall_kick <= ~stall_kick;
          stalled = 1'b1;
        end
        random_burst();
      end
    end

    in_tvalid <= 1'b0;
    while (lamp_expect.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    fails = mism_cnt + lamp_expect.size();
    $display("ran %0d ticks over %0d period settings plus directed cases, %0d results checked",
             ticks_sent, settings_run, results_seen);
    $display("ticks ending in stop/go/warn/off: %0d/%0d/%0d/%0d, mismatches: %0d",
             ph_seen[PH_STOP], ph_seen[PH_GO], ph_seen[PH_WARN], ph_seen[PH_OFF], mism_cnt);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### traffic_light_sequencer.f
rtl/tls_pkg.sv
rtl/tls_core.sv
rtl/traffic_light_sequencer.sv
rtl/tls_checker.sv
dv/tb.sv
